### src/bbhr_pkg.sv
// ----------------------------------------------------------------------------
// bbhr_pkg: shared types and constants of the byte budget history ring
// Ring depth, derived widths, op and refusal codes, and the store port structs.
// ----------------------------------------------------------------------------
package bbhr_pkg;

   localparam int DEPTH     = 64;
   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = AW + 1;
   localparam int TICK_W    = 32;
   localparam int SIZE_W    = 32;
   localparam int TOTAL_W   = 39;
   localparam int BUDGET_W  = 40;

   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

   typedef enum logic [1:0] {
      OP_CAPTURE = 2'd0,
      OP_FIND    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      REF_NONE   = 2'd0,
      REF_RESYNC = 2'd1,
      REF_FUTURE = 2'd2,
      REF_EMPTY  = 2'd3
   } refusal_type;

   // One write port, two tick read ports, one size read port.
   typedef struct packed {
      logic              wr_en;
      logic [AW-1:0]     wr_addr;
      logic [TICK_W-1:0] wr_tick;
      logic [SIZE_W-1:0] wr_size;
      logic [AW-1:0]     rd_a_addr;
      logic [AW-1:0]     rd_b_addr;
      logic [AW-1:0]     rd_s_addr;
   } store_req_type;

   typedef struct packed {
      logic [TICK_W-1:0] tick_a;
      logic [TICK_W-1:0] tick_b;
      logic [SIZE_W-1:0] size_s;
   } store_rsp_type;

   // Slot of the record at a given age, counted from the oldest slot.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [CW-1:0] age);
      logic [CW:0] sum;
      sum = {2'b00, base} + {1'b0, age};
      if (sum >= (CW+1)'(DEPTH)) begin
         sum = sum - (CW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

endpackage

### src/bbhr_store.sv
// ----------------------------------------------------------------------------
// bbhr_store: record storage of the history ring
// Tick and size memories, one write port, registered read data.
// ----------------------------------------------------------------------------
module bbhr_store
   import bbhr_pkg::*;
(
   input  logic          clock,
   input  store_req_type req,
   output store_rsp_type rsp
);

   logic [TICK_W-1:0] tick_mem [DEPTH];
   logic [SIZE_W-1:0] size_mem [DEPTH];
   logic [TICK_W-1:0] tick_a_ff;
   logic [TICK_W-1:0] tick_b_ff;
   logic [SIZE_W-1:0] size_s_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         tick_mem[req.wr_addr] <= req.wr_tick;
         size_mem[req.wr_addr] <= req.wr_size;
      end
   end

   always_ff @(posedge clock) begin
      tick_a_ff <= tick_mem[req.rd_a_addr];
      tick_b_ff <= tick_mem[req.rd_b_addr];
      size_s_ff <= size_mem[req.rd_s_addr];
   end

   assign rsp.tick_a = tick_a_ff;
   assign rsp.tick_b = tick_b_ff;
   assign rsp.size_s = size_s_ff;

endmodule

### src/byte_budget_history_ring.sv
// ----------------------------------------------------------------------------
// byte_budget_history_ring: ordered window of snapshot records under a budget
// Capture appends a record and evicts oldest records when full or past the budget;
// find returns the newest record at or below a tick; clear empties the ring.
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  --------  ----------------------------  -------------------------------------
//  request   req_op, req_tick,             word taken when start & !busy
//            req_record_bytes
//  response  rsp_refusal ... rsp_window_   rsp_valid high one cycle per word,
//            span                          always taken
//  config    csr_wdata                     written when csr_valid & csr_ready,
//                                          ready only while idle
//
//  Steps (busy high, the word appears in the first cycle with busy low):
//    capture: full-ring eviction if needed, append, then budget evictions;
//    find: no walk when empty, the oldest-tick check alone on a resync
//    refusal, else that check and a read/compare pair per held record;
//    clear and unused op: no walk. All end with span read, then finish.
//  Reset is synchronous and empties the ring; the budget returns to 16 MiB.
//  The receiver cannot stall; a new request may start in the response cycle.
//
module byte_budget_history_ring
   import bbhr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_op,
   input  logic [TICK_W-1:0]   req_tick,
   input  logic [SIZE_W-1:0]   req_record_bytes,
   // response
   output logic                rsp_valid,
   output logic [1:0]          rsp_refusal,
   output logic                rsp_found,
   output logic [31:0]         rsp_found_tick,
   output logic [5:0]          rsp_found_position,
   output logic [6:0]          rsp_evicted_now,
   output logic [6:0]          rsp_held_count,
   output logic [37:0]         rsp_held_bytes,
   output logic [31:0]         rsp_window_span,
   // configuration
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BUDGET_W-1:0] csr_wdata
);

   typedef enum logic [10:0] {
      ST_IDLE     = 11'b000_0000_0001,
      ST_EV_RD    = 11'b000_0000_0010,
      ST_EV_UPD   = 11'b000_0000_0100,
      ST_APPEND   = 11'b000_0000_1000,
      ST_BUDGET   = 11'b000_0001_0000,
      ST_FIND_RD  = 11'b000_0010_0000,
      ST_FIND_CHK = 11'b000_0100_0000,
      ST_SCAN_RD  = 11'b000_1000_0000,
      ST_SCAN_CMP = 11'b001_0000_0000,
      ST_SPAN_RD  = 11'b010_0000_0000,
      ST_FINISH   = 11'b100_0000_0000
   } state_type;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = BUDGET_W'(40'd16777216);

   state_type           state_ff, state_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [AW-1:0]       oldest_ff, oldest_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                full_evict_ff, full_evict_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // request word held for the duration of the operation
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [SIZE_W-1:0]   bytes_ff, bytes_in;

   // find walk
   logic [CW-1:0]       age_ff, age_in;

   // response word
   refusal_type         refusal_ff, refusal_in;
   logic                found_ff, found_in;
   logic [TICK_W-1:0]   ftick_ff, ftick_in;
   logic [5:0]          fpos_ff, fpos_in;
   logic [6:0]          evicted_ff, evicted_in;
   logic [6:0]          held_count_ff, held_count_in;
   logic [37:0]         held_bytes_ff, held_bytes_in;
   logic [31:0]         span_ff, span_in;

   store_req_type       store_req;
   store_rsp_type       store_rsp;
   logic [CW-1:0]       newest_age;

   bbhr_store u_store (
      .clock (clock),
      .req   (store_req),
      .rsp   (store_rsp)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   // newest record sits at age count-1; guard the empty ring
   assign newest_age = (count_ff == '0) ? '0 : count_ff - CW'(1);

   // Store addressing follows the state: evictions read the oldest size, the
   // find walk and span read ticks on port A, span reads the newest on port B.
   always_comb begin
      store_req           = '0;
      store_req.wr_addr   = slot_of(oldest_ff, count_ff);
      store_req.wr_tick   = tick_ff;
      store_req.wr_size   = bytes_ff;
      store_req.wr_en     = (state_ff == ST_APPEND);
      store_req.rd_s_addr = oldest_ff;
      store_req.rd_b_addr = slot_of(oldest_ff, newest_age);
      if (state_ff == ST_SCAN_RD) begin
         store_req.rd_a_addr = slot_of(oldest_ff, age_ff);
      end else begin
         store_req.rd_a_addr = oldest_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      budget_in     = budget_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      full_evict_in = full_evict_ff;
      rsp_valid_in  = 1'b0;
      tick_in       = tick_ff;
      bytes_in      = bytes_ff;
      age_in        = age_ff;
      refusal_in    = refusal_ff;
      found_in      = found_ff;
      ftick_in      = ftick_ff;
      fpos_in       = fpos_ff;
      evicted_in    = evicted_ff;
      held_count_in = held_count_ff;
      held_bytes_in = held_bytes_ff;
      span_in       = span_ff;

      // take budget writes only while idle
      if (csr_valid && csr_ready) begin
         budget_in = csr_wdata;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               tick_in       = req_tick;
               bytes_in      = req_record_bytes;
               refusal_in    = REF_NONE;
               found_in      = 1'b0;
               ftick_in      = '0;
               fpos_in       = '0;
               evicted_in    = '0;
               full_evict_in = 1'b0;
               unique case (op_type'(req_op))
                  OP_CAPTURE: begin
                     // full ring: drop the oldest before the append
                     if (count_ff >= FULL_CNT) begin
                        full_evict_in = 1'b1;
                        state_in      = ST_EV_RD;
                     end else begin
                        state_in = ST_APPEND;
                     end
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        refusal_in = REF_EMPTY;
                        state_in   = ST_SPAN_RD;
                     end else begin
                        state_in = ST_FIND_RD;
                     end
                  end
                  OP_CLEAR: begin
                     count_in  = '0;
                     oldest_in = '0;
                     total_in  = '0;
                     state_in  = ST_SPAN_RD;
                  end
                  default: begin
                     state_in = ST_SPAN_RD;
                  end
               endcase
            end
         end

         ST_EV_RD: begin
            // size of the oldest record lands next cycle
            state_in = ST_EV_UPD;
         end

         ST_EV_UPD: begin
            total_in   = total_ff - TOTAL_W'(store_rsp.size_s);
            oldest_in  = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + AW'(1);
            count_in   = count_ff - CW'(1);
            evicted_in = evicted_ff + 7'd1;
            if (full_evict_ff) begin
               full_evict_in = 1'b0;
               state_in      = ST_APPEND;
            end else begin
               state_in = ST_BUDGET;
            end
         end

         ST_APPEND: begin
            count_in = count_ff + CW'(1);
            total_in = total_ff + TOTAL_W'(bytes_ff);
            state_in = ST_BUDGET;
         end

         ST_BUDGET: begin
            // keep the newest record even when it alone exceeds the budget
            if (count_ff > CW'(1) && BUDGET_W'(total_ff) > budget_ff) begin
               state_in = ST_EV_RD;
            end else begin
               state_in = ST_SPAN_RD;
            end
         end

         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end

         ST_FIND_CHK: begin
            if (tick_ff < store_rsp.tick_a) begin
               refusal_in = REF_RESYNC;
               state_in   = ST_SPAN_RD;
            end else begin
               age_in   = '0;
               state_in = ST_SCAN_RD;
            end
         end

         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            // later ages overwrite earlier hits: the newest match wins
            if (store_rsp.tick_a <= tick_ff) begin
               found_in = 1'b1;
               ftick_in = store_rsp.tick_a;
               fpos_in  = 6'(age_ff);
            end
            age_in = age_ff + CW'(1);
            if (age_ff + CW'(1) >= count_ff) begin
               if (!found_ff && !(store_rsp.tick_a <= tick_ff)) begin
                  refusal_in = REF_FUTURE;
               end
               state_in = ST_SPAN_RD;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end

         ST_SPAN_RD: begin
            // oldest tick on port A, newest on port B
            state_in = ST_FINISH;
         end

         ST_FINISH: begin
            held_count_in = 7'(count_ff);
            held_bytes_in = total_ff[37:0];
            if (count_ff >= CW'(2)) begin
               span_in = store_rsp.tick_b - store_rsp.tick_a;
            end else begin
               span_in = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         budget_ff     <= BUDGET_RESET;
         oldest_ff     <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         full_evict_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         budget_ff     <= budget_in;
         oldest_ff     <= oldest_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         full_evict_ff <= full_evict_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      bytes_ff      <= bytes_in;
      age_ff        <= age_in;
      refusal_ff    <= refusal_in;
      found_ff      <= found_in;
      ftick_ff      <= ftick_in;
      fpos_ff       <= fpos_in;
      evicted_ff    <= evicted_in;
      held_count_ff <= held_count_in;
      held_bytes_ff <= held_bytes_in;
      span_ff       <= span_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_refusal        = refusal_ff;
   assign rsp_found          = found_ff;
   assign rsp_found_tick     = ftick_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_evicted_now    = evicted_ff;
   assign rsp_held_count     = held_count_ff;
   assign rsp_held_bytes     = held_bytes_ff;
   assign rsp_window_span    = span_ff;

endmodule
